### src/divide_and_sqrt_unit_defines.svh
// Assertion macros for the divide and square-root unit.
// Included by the top level; no other dependencies.
// Define NO_ASSERTIONS to drop every check.
`ifndef DIVIDE_AND_SQRT_UNIT_DEFINES_SVH
`define DIVIDE_AND_SQRT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsu assertion failed");
`define DSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsu assertion failed");
`else
`define DSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/dsu_pkg.sv
// Shared types and operation codes for the divide and square-root unit.
// No dependencies.
package dsu_pkg;

  localparam logic [1:0] FUNC_UDIV = 2'd0;
  localparam logic [1:0] FUNC_SDIV = 2'd1;
  localparam logic [1:0] FUNC_SQRT = 2'd2;

  // per-item control that rides along the cell chain
  typedef struct packed {
    logic is_sqrt;
    logic neg_q;
    logic neg_r;
    logic dz;
  } dsu_ctl_t;

endpackage

### src/dsu_prep.sv
// Input stage: operand decode, sign stripping, chain preload.
// Depends on dsu_pkg.
module dsu_prep import dsu_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [1:0]    func_i,
  input  logic [31:0]   a_i,
  input  logic [31:0]   b_i,
  output logic          valid_o,
  input  logic          ready_i,
  output dsu_ctl_t      ctl_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] aq_o,
  output logic [DW-1:0] b_o
);

  logic          v_r;
  dsu_ctl_t      ctl_r, ctl_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] aq_r, aq_nxt;
  logic [DW-1:0] b_r, b_nxt;
  logic [DW-1:0] a_w, b_w, ma, mb;
  logic          sgn, na, nb;

  assign a_w = DW'(a_i);
  assign b_w = DW'(b_i);
  assign sgn = (func_i == FUNC_SDIV);
  assign na  = sgn & a_w[DW-1];
  assign nb  = sgn & b_w[DW-1];
  assign ma  = na ? (~a_w + 1'b1) : a_w;
  assign mb  = nb ? (~b_w + 1'b1) : b_w;

  always_comb begin
    ctl_nxt.is_sqrt = (func_i != FUNC_UDIV) && (func_i != FUNC_SDIV);
    ctl_nxt.neg_q   = na ^ nb;
    ctl_nxt.neg_r   = na;
    ctl_nxt.dz      = !ctl_nxt.is_sqrt && (b_w == '0);
    if (ctl_nxt.is_sqrt) begin
      rem_nxt = a_w;
      aq_nxt  = '0;
    end else begin
      rem_nxt = '0;
      aq_nxt  = ma;
    end
    b_nxt = mb;
  end

  assign ready_o = !v_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      ctl_r <= ctl_nxt;
      rem_r <= rem_nxt;
      aq_r  <= aq_nxt;
      b_r   <= b_nxt;
    end
  end

  assign valid_o = v_r;
  assign ctl_o   = ctl_r;
  assign rem_o   = rem_r;
  assign aq_o    = aq_r;
  assign b_o     = b_r;

endmodule

### src/dsu_cell.sv
// One cell of the chain: a restoring divide step or a square-root digit step.
// Depends on dsu_pkg.
module dsu_cell import dsu_pkg::*; #(
  parameter int DW    = 32,
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  dsu_ctl_t      ctl_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] aq_i,
  input  logic [DW-1:0] b_i,
  output logic          valid_o,
  input  logic          ready_i,
  output dsu_ctl_t      ctl_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] aq_o,
  output logic [DW-1:0] b_o
);

  localparam int TOP        = ((DW - 1) / 2) * 2;
  localparam int SQRT_STEPS = TOP / 2 + 1;

  logic          v_r;
  dsu_ctl_t      ctl_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] aq_r, aq_nxt;
  logic [DW-1:0] b_r;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          div_ge;
  logic [DW-1:0] div_rem, div_aq;
  logic [DW-1:0] sq_rem, sq_root;

  // divide: shift next dividend bit into the partial remainder
  assign trial   = {rem_i, aq_i[DW-1]};
  assign diff    = {1'b0, trial} - {2'b00, b_i};
  assign div_ge  = !diff[DW+1];
  assign div_rem = div_ge ? diff[DW-1:0] : trial[DW-1:0];
  assign div_aq  = {aq_i[DW-2:0], div_ge};

  generate
    if (STAGE < SQRT_STEPS) begin : g_sqrt
      localparam int          BITPOS = TOP - 2 * STAGE;
      localparam logic [DW:0] SQ_BIT = (DW+1)'(1) << BITPOS;
      logic [DW:0] sum;
      logic        sq_ge;
      assign sum     = {1'b0, aq_i} + SQ_BIT;
      assign sq_ge   = ({1'b0, rem_i} >= sum);
      assign sq_rem  = sq_ge ? (rem_i - sum[DW-1:0]) : rem_i;
      assign sq_root = sq_ge ? ((aq_i >> 1) + SQ_BIT[DW-1:0]) : (aq_i >> 1);
    end else begin : g_hold
      assign sq_rem  = rem_i;
      assign sq_root = aq_i;
    end
  endgenerate

  assign rem_nxt = ctl_i.is_sqrt ? sq_rem  : div_rem;
  assign aq_nxt  = ctl_i.is_sqrt ? sq_root : div_aq;

  assign ready_o = !v_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      ctl_r <= ctl_i;
      rem_r <= rem_nxt;
      aq_r  <= aq_nxt;
      b_r   <= b_i;
    end
  end

  assign valid_o = v_r;
  assign ctl_o   = ctl_r;
  assign rem_o   = rem_r;
  assign aq_o    = aq_r;
  assign b_o     = b_r;

endmodule

### src/dsu_post.sv
// Output stage: sign restore, divide-by-zero override, result register.
// Depends on dsu_pkg.
module dsu_post import dsu_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  dsu_ctl_t      ctl_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] aq_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [31:0]   quotient_o,
  output logic [31:0]   remainder_o,
  output logic          status_o
);

  logic          v_r;
  logic [31:0]   q_r, q_nxt;
  logic [31:0]   r_r, r_nxt;
  logic          st_r, st_nxt;
  logic [DW-1:0] q_fix, r_fix;

  always_comb begin
    q_fix = aq_i;
    r_fix = rem_i;
    if (!ctl_i.is_sqrt) begin
      if (ctl_i.neg_q) q_fix = ~aq_i + 1'b1;
      if (ctl_i.neg_r) r_fix = ~rem_i + 1'b1;
    end
    if (ctl_i.dz) begin
      q_nxt  = '0;
      r_nxt  = '0;
      st_nxt = 1'b1;
    end else begin
      q_nxt  = 32'(q_fix);
      r_nxt  = 32'(r_fix);
      st_nxt = 1'b0;
    end
  end

  assign ready_o = !v_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      q_r  <= q_nxt;
      r_r  <= r_nxt;
      st_r <= st_nxt;
    end
  end

  assign valid_o     = v_r;
  assign quotient_o  = q_r;
  assign remainder_o = r_r;
  assign status_o    = st_r;

endmodule

### src/divide_and_sqrt_unit.sv
// Divide and square-root unit, top level: input stage, cell chain, output stage.
// Depends on dsu_pkg, dsu_prep, dsu_cell, dsu_post and the assertion macro header.
//
// Takes one item per clock while the output is not stalled, and returns one
// result per item, in order. An item passes an input register, one cell per
// quotient bit (each cell does one restoring divide step, or one root digit
// step for the square root), and the output register. Every stage
// holds its item only while the stage after it is full and stalled, so
// bubbles close up and the input keeps taking items while a result waits.
// Divide by zero returns status 1 with zero quotient and remainder.
`include "divide_and_sqrt_unit_defines.svh"

module divide_and_sqrt_unit import dsu_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // quotient[31:0], remainder_out[63:32]
  output logic [0:0]  out_tuser   // status[0]
);

  localparam int DW = DATA_WIDTH;

  logic          lnk_v   [DW+1];
  logic          lnk_rdy [DW+1];
  dsu_ctl_t      lnk_ctl [DW+1];
  logic [DW-1:0] lnk_rem [DW+1];
  logic [DW-1:0] lnk_aq  [DW+1];
  logic [DW-1:0] lnk_b   [DW+1];
  logic [DW:0]   v_vec;
  logic [31:0]   q_w, r_w;
  logic          st_w;

  dsu_prep #(.DW(DW)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .func_i  (in_tuser),
    .a_i     (in_tdata[31:0]),
    .b_i     (in_tdata[63:32]),
    .valid_o (lnk_v[0]),
    .ready_i (lnk_rdy[0]),
    .ctl_o   (lnk_ctl[0]),
    .rem_o   (lnk_rem[0]),
    .aq_o    (lnk_aq[0]),
    .b_o     (lnk_b[0])
  );

  genvar k;
  generate
    for (k = 0; k < DW; k++) begin : g_cell
      dsu_cell #(.DW(DW), .STAGE(k)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (lnk_v[k]),
        .ready_o (lnk_rdy[k]),
        .ctl_i   (lnk_ctl[k]),
        .rem_i   (lnk_rem[k]),
        .aq_i    (lnk_aq[k]),
        .b_i     (lnk_b[k]),
        .valid_o (lnk_v[k+1]),
        .ready_i (lnk_rdy[k+1]),
        .ctl_o   (lnk_ctl[k+1]),
        .rem_o   (lnk_rem[k+1]),
        .aq_o    (lnk_aq[k+1]),
        .b_o     (lnk_b[k+1])
      );
    end
    for (k = 0; k <= DW; k++) begin : g_vvec
      assign v_vec[k] = lnk_v[k];
    end
  endgenerate

  dsu_post #(.DW(DW)) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (lnk_v[DW]),
    .ready_o     (lnk_rdy[DW]),
    .ctl_i       (lnk_ctl[DW]),
    .rem_i       (lnk_rem[DW]),
    .aq_i        (lnk_aq[DW]),
    .valid_o     (out_tvalid),
    .ready_i     (out_tready),
    .quotient_o  (q_w),
    .remainder_o (r_w),
    .status_o    (st_w)
  );

  assign out_tdata    = {r_w, q_w};
  assign out_tuser[0] = st_w;

  // divide by zero always comes with zeroed results
  `DSU_ASSERT_IMPLIES(a_dz_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0)
  // a taken output frees the whole chain
  `DSU_ASSERT_IMPLIES(a_ready_chain, clk, rst_n, out_tready, in_tready)
  // an empty chain always takes input
  `DSU_ASSERT_IMPLIES(a_empty_ready, clk, rst_n, (v_vec == '0) && !out_tvalid, in_tready)
  // an accepted item lands in the input register
  `DSU_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_tvalid && in_tready, lnk_v[0])

endmodule

### tb/tb_divide_and_sqrt_unit.sv
// Self-checking testbench for divide_and_sqrt_unit: directed table, then random stream.
// Depends on dsu_pkg and the divide_and_sqrt_unit RTL; predicts each result itself.
`timescale 1ns / 100ps

module tb_divide_and_sqrt_unit;
  import dsu_pkg::*;

  localparam logic [1:0] FUNC_RSVD = 2'd3;  // decodes as root
  localparam int RANDOM_ITEMS = 1380;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 4000;
  localparam int DIR_ROWS = 23;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] opa;
    logic [31:0] opb;
  } dsu_op_t;

  typedef struct packed {
    logic [31:0] quot;
    logic [31:0] remd;
    logic        status;
  } dsu_result_t;

  typedef struct packed {
    dsu_op_t     op;
    logic        lit;
    dsu_result_t res;
  } dir_row_t;

  localparam dsu_result_t NO_LIT = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // operand_a[31:0], operand_b[63:32]
  logic [1:0]  in_tuser = '0;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // quotient[31:0], remainder_out[63:32]
  logic [0:0]  out_tuser;       // status[0]

  dsu_result_t pending_results[$];
  logic        hold_off = 1'b0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          err_count = 0;
  int          udiv_cnt = 0;
  int          sdiv_cnt = 0;
  int          sqrt_cnt = 0;
  int          dz_cnt = 0;
  int          stall_cycles = 0;
  int          rx_mode = 0;
  int          rx_cycle = 0;

  divide_and_sqrt_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic dsu_result_t div_sqrt_predict(dsu_op_t op);
    dsu_result_t res;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] root;
    logic [31:0] trial;
    res = '0;
    if (op.func == FUNC_SQRT || op.func == FUNC_RSVD) begin
      root = '0;
      for (int i = 15; i >= 0; i--) begin
        trial = root | (32'd1 << i);
        if (64'(trial) * 64'(trial) <= 64'(op.opa)) begin
          root = trial;
        end
      end
      res.quot = root;
      res.remd = op.opa - root * root;
    end else if (op.opb == '0) begin
      res.status = 1'b1;
    end else if (op.func == FUNC_UDIV) begin
      res.quot = op.opa / op.opb;
      res.remd = op.opa % op.opb;
    end else begin
      mag_a = op.opa[31] ? -op.opa : op.opa;
      mag_b = op.opb[31] ? -op.opb : op.opb;
      res.quot = mag_a / mag_b;
      res.remd = mag_a % mag_b;
      if (op.opa[31] != op.opb[31]) begin
        res.quot = -res.quot;
      end
      if (op.opa[31]) begin
        res.remd = -res.remd;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      4: w = $urandom_range(0, 255);
      5: begin
        case ($urandom_range(0, 4))
          0: w = 32'h0000_0000;
          1: w = 32'h0000_0001;
          2: w = 32'hFFFF_FFFF;
          3: w = 32'h8000_0000;
          default: w = 32'h7FFF_FFFF;
        endcase
      end
      6: w = $urandom >> $urandom_range(0, 31);
      7: w = -($urandom_range(1, 300));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic dsu_op_t rand_op();
    dsu_op_t op;
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2: op.func = FUNC_UDIV;
      3, 4, 5: op.func = FUNC_SDIV;
      9: op.func = FUNC_RSVD;
      default: op.func = FUNC_SQRT;
    endcase
    op.opa = rand_word();
    op.opb = ($urandom_range(0, 29) == 0) ? 32'd0 : rand_word();
    if (op.func[1] && $urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 65535);
      case ($urandom_range(0, 3))
        0: op.opa = r * r - 1;
        1: op.opa = r * r;
        2: op.opa = r * r + 1;
        default: op.opa = r * r + 2 * r;
      endcase
    end
    return op;
  endfunction

  task automatic send_item(input dsu_op_t op, input dsu_result_t res);
    in_tvalid <= 1'b1;
    in_tdata  <= {op.opb, op.opa};
    in_tuser  <= op.func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(res);
    items_sent++;
    if (op.func[1]) sqrt_cnt++;
    else if (op.func == FUNC_UDIV) udiv_cnt++;
    else sdiv_cnt++;
    if (res.status) dz_cnt++;
  endtask

  // directed rows: extremes, signs, divide by zero, root edges, unused selector
  dir_row_t dir_table [DIR_ROWS] = '{
    '{'{FUNC_UDIV, 32'hFFFF_FFFF, 32'd1}, 1'b1, '{32'hFFFF_FFFF, 32'd0, 1'b0}},
    '{'{FUNC_UDIV, 32'd0, 32'd0}, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{'{FUNC_UDIV, 32'hFFFF_FFFF, 32'd0}, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{'{FUNC_SDIV, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b1, '{32'h8000_0000, 32'd0, 1'b0}},
    '{'{FUNC_SDIV, 32'd5, 32'd0}, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{'{FUNC_SDIV, 32'hFFFF_FFF9, 32'd2}, 1'b0, NO_LIT},
    '{'{FUNC_SDIV, 32'd7, 32'hFFFF_FFFE}, 1'b0, NO_LIT},
    '{'{FUNC_SDIV, 32'hFFFF_FFF9, 32'hFFFF_FFFE}, 1'b0, NO_LIT},
    '{'{FUNC_SDIV, 32'h8000_0000, 32'd1}, 1'b1, '{32'h8000_0000, 32'd0, 1'b0}},
    '{'{FUNC_SDIV, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, NO_LIT},
    '{'{FUNC_SDIV, 32'h8000_0000, 32'h8000_0000}, 1'b1, '{32'd1, 32'd0, 1'b0}},
    '{'{FUNC_UDIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'd1, 32'd0, 1'b0}},
    '{'{FUNC_UDIV, 32'h1234_5678, 32'h0000_0100}, 1'b0, NO_LIT},
    '{'{FUNC_UDIV, 32'd0, 32'd5}, 1'b1, '{32'd0, 32'd0, 1'b0}},
    '{'{FUNC_UDIV, 32'd1, 32'hFFFF_FFFF}, 1'b1, '{32'd0, 32'd1, 1'b0}},
    '{'{FUNC_SQRT, 32'd0, 32'd0}, 1'b1, '{32'd0, 32'd0, 1'b0}},
    '{'{FUNC_SQRT, 32'hFFFF_FFFF, 32'd7}, 1'b1, '{32'h0000_FFFF, 32'h0001_FFFE, 1'b0}},
    '{'{FUNC_SQRT, 32'hFFFE_0001, 32'd0}, 1'b1, '{32'h0000_FFFF, 32'd0, 1'b0}},
    '{'{FUNC_SQRT, 32'd1, 32'd0}, 1'b1, '{32'd1, 32'd0, 1'b0}},
    '{'{FUNC_SQRT, 32'd2, 32'd0}, 1'b1, '{32'd1, 32'd1, 1'b0}},
    '{'{FUNC_RSVD, 32'h0001_0000, 32'hFFFF_FFFF}, 1'b1, '{32'h0000_0100, 32'd0, 1'b0}},
    '{'{FUNC_RSVD, 32'd99, 32'd3}, 1'b0, NO_LIT},
    '{'{FUNC_SQRT, 32'hFFFE_0000, 32'h8000_0000}, 1'b0, NO_LIT}
  };

  // stimulus and end of run
  initial begin
    dsu_op_t     op;
    dsu_result_t res;
    int          burst_left;
    int          gap;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      op  = dir_table[i].op;
      res = dir_table[i].lit ? dir_table[i].res : div_sqrt_predict(op);
      send_item(op, res);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = (hold_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      op = rand_op();
      send_item(op, div_sqrt_predict(op));
    end
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d unsigned div, %0d signed div, %0d root, %0d div by zero",
             items_sent, udiv_cnt, sdiv_cnt, sqrt_cnt, dz_cnt);
    $display("Checked %0d results with %0d mismatches", results_checked, err_count);
    if (err_count == 0) begin
      $display("tb_divide_and_sqrt_unit passed");
    end else begin
      $display("tb_divide_and_sqrt_unit failed");
    end
    $finish;
  end

  // long receiver hold-off so the pipe fills and backs up the input
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // receiver: stall pattern and result check
  always @(posedge clk) begin
    dsu_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result q=%h r=%h st=%b", $time,
                 out_tdata[31:0], out_tdata[63:32], out_tuser[0]);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[31:0] !== exp_res.quot) begin
          $display("%0t: quotient expected %h actual %h", $time, exp_res.quot,
                   out_tdata[31:0]);
          err_count++;
        end
        if (out_tdata[63:32] !== exp_res.remd) begin
          $display("%0t: remainder expected %h actual %h", $time, exp_res.remd,
                   out_tdata[63:32]);
          err_count++;
        end
        if (out_tuser[0] !== exp_res.status) begin
          $display("%0t: status expected %b actual %b", $time, exp_res.status,
                   out_tuser[0]);
          err_count++;
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_cycle % 7 < 4);
      endcase
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, stall_cycles);
        $display("tb_divide_and_sqrt_unit failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
